// ----- sv/bttm_pkg.sv -----
// Shared types and constants for the battery trend monitor.
// Has no dependencies. The core and the top level import it.
package bttm_pkg;

    // Stage counter thresholds
    localparam logic [7:0] STAGE_SEED   = 8'd32;
    localparam logic [7:0] STAGE_SETTLE = 8'd64;
    localparam logic [7:0] STAGE_MAX    = 8'd255;

    // Curvature threshold after reset
    localparam logic signed [15:0] THRESH_RESET = 16'sd800;

    typedef struct packed {
        logic signed [15:0] level;
        logic signed [15:0] slope;
        logic signed [15:0] curvature;
        logic               batt_low;
        logic               settled;
    } result_t;

endpackage

// ----- sv/bttm_trend_core.sv -----
// Trend state and the combinational update of level, slope and curvature.
// Depends on bttm_pkg. The top level instantiates it.
module bttm_trend_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic signed [12:0]   reading,
    input  logic signed [15:0]   threshold,
    output bttm_pkg::result_t    result
);
    import bttm_pkg::*;

    logic [7:0]         stage_reg,   stage_next;
    logic signed [15:0] level_reg,   level_next;
    logic signed [15:0] level32_reg, level32_next;
    logic signed [15:0] slope_reg,   slope_next;
    logic signed [15:0] curv_reg,    curv_next;
    logic               low_reg,     low_next;

    logic signed [15:0] raw_level;
    logic signed [16:0] d_level;
    logic signed [15:0] level_filt;
    logic signed [15:0] seed_diff;
    logic signed [15:0] slope_x;
    logic signed [16:0] d_slope;
    logic signed [15:0] slope_filt;
    logic signed [15:0] curv_x;
    logic signed [16:0] d_curv;
    logic signed [15:0] curv_filt;
    logic               settled;

    always_comb begin
        stage_next = (stage_reg == STAGE_MAX) ? stage_reg : stage_reg + 8'd1;

        // reading * 64, kept to 16 bits
        raw_level  = {reading[9:0], 6'b000000};

        // 1/256 filter on the level; the arithmetic shift floors
        d_level    = {raw_level[15], raw_level} - {level_reg[15], level_reg};
        level_filt = level_reg + {{7{d_level[16]}}, d_level[16:8]};

        // Per-item level change times 256 is the low byte of the shifted step
        slope_x    = {d_level[15:8], 8'h00};
        d_slope    = {slope_x[15], slope_x} - {slope_reg[15], slope_reg};
        slope_filt = slope_reg + {{7{d_slope[16]}}, d_slope[16:8]};

        // Per-item slope change times 512
        curv_x     = {d_slope[14:8], 9'b000000000};
        d_curv     = {curv_x[15], curv_x} - {curv_reg[15], curv_reg};
        curv_filt  = curv_reg + {{7{d_curv[16]}}, d_curv[16:8]};

        level_next   = level_reg;
        level32_next = level32_reg;
        if (stage_next == STAGE_SEED) begin
            level_next   = raw_level;
            level32_next = raw_level;
        end else if (stage_next > STAGE_SEED) begin
            level_next   = level_filt;
        end

        seed_diff  = level_next - level32_reg;
        slope_next = slope_reg;
        curv_next  = curv_reg;
        if (stage_next == STAGE_SETTLE) begin
            slope_next = {seed_diff[12:0], 3'b000};
            curv_next  = '0;
        end else if (stage_next > STAGE_SETTLE) begin
            slope_next = slope_filt;
            curv_next  = curv_filt;
        end

        settled  = (stage_next >= STAGE_SETTLE);
        low_next = settled ? (!slope_next[15] && (curv_next >= threshold)) : low_reg;

        result.level     = level_next;
        result.slope     = slope_next;
        result.curvature = curv_next;
        result.batt_low  = low_next;
        result.settled   = settled;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg   <= '0;
            level_reg   <= '0;
            level32_reg <= '0;
            slope_reg   <= '0;
            curv_reg    <= '0;
            low_reg     <= 1'b0;
        end else if (step) begin
            stage_reg   <= stage_next;
            level_reg   <= level_next;
            level32_reg <= level32_next;
            slope_reg   <= slope_next;
            curv_reg    <= curv_next;
            low_reg     <= low_next;
        end
    end

endmodule

// ----- sv/battery_trend_monitor.sv -----
// Battery trend monitor: a request is accepted into the input register, then moves on to the
// result register, from which it is offered. Throughput one request per cycle unless the output
// stalls (m_ready low); the trend state updates as a request moves from the input register to the
// result register. Reset (aresetn, synchronous, active low) clears the stage count, the trend state
// and both valid flags, and loads the curvature threshold with 800.
module battery_trend_monitor (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic signed [15:0]  cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [12:0]  s_reading,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_level,
    output logic signed [15:0]  m_slope,
    output logic signed [15:0]  m_curvature,
    output logic                m_batt_low,
    output logic                m_settled
);
    import bttm_pkg::*;

    // Configuration: the curvature threshold
    logic signed [15:0] thresh_reg;

    // Input register stage
    logic               in_valid_reg;
    logic signed [12:0] in_reading_reg;

    // Result register stage
    logic               res_valid_reg;
    result_t            res_reg;
    result_t            res_next;

    logic               out_free;
    logic               advance;

    // The result register can take a new request when empty or being drained.
    // A request advances out of the input register exactly when it can land;
    // that same edge commits the trend state update.
    assign out_free = !res_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_we) begin
            thresh_reg <= cfg_wdata;
        end
    end

    // Hold the request until the result stage accepts it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reading_reg <= s_reading;
        end
    end

    bttm_trend_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .reading   (in_reading_reg),
        .threshold (thresh_reg),
        .result    (res_next)
    );

    // Load the result when a request advances; drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (out_free) begin
            res_valid_reg <= advance;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid     = res_valid_reg;
    assign m_level     = res_reg.level;
    assign m_slope     = res_reg.slope;
    assign m_curvature = res_reg.curvature;
    assign m_batt_low  = res_reg.batt_low;
    assign m_settled   = res_reg.settled;

`ifndef SYNTHESIS
    // A held request is never lost without advancing
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input request dropped without advancing");

    // A new request is only taken into a full input stage when it empties
    a_in_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && in_valid_reg) |-> advance)
        else $error("input register overwritten");

    // Low battery is only ever flagged once settled
    a_low_needs_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_batt_low) |-> m_settled)
        else $error("low battery flagged before settling");

    // Low battery requires a non-negative slope
    a_low_needs_slope: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_batt_low) |-> !m_slope[15])
        else $error("low battery flagged with negative slope");
`endif

endmodule
